// ===== hdl/smaa_pkg.sv =====
// ----------------------------------------------------------------------------
// smaa_pkg
// Shared types and constants for the sensor moving average alarm block.
// ----------------------------------------------------------------------------
package smaa_pkg;

  // number of sensor channels held in the window
  localparam int NCH = 5;

  // field widths of one sample
  localparam int TEMP_W  = 11;
  localparam int HUMID_W = 10;
  localparam int PRESS_W = 14;
  localparam int LPG_W   = 14;
  localparam int SMOKE_W = 14;

  // widest field, also the width of the stored means
  localparam int MEAN_W = 14;

  // bit positions of the channels in one packed window word
  localparam int TEMP_LSB  = 0;
  localparam int HUMID_LSB = TEMP_LSB + TEMP_W;
  localparam int PRESS_LSB = HUMID_LSB + HUMID_W;
  localparam int LPG_LSB   = PRESS_LSB + PRESS_W;
  localparam int SMOKE_LSB = LPG_LSB + LPG_W;
  localparam int SAMPLE_W  = SMOKE_LSB + SMOKE_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LIMIT  = 2'd0,
    CFG_LPG_LIMIT   = 2'd1,
    CFG_SMOKE_LIMIT = 2'd2
  } cfg_index_t;

  // register reset values
  localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST  = 11'sd220;
  localparam logic [LPG_W-1:0]         LPG_LIMIT_RST   = 14'd800;
  localparam logic [SMOKE_W-1:0]       SMOKE_LIMIT_RST = 14'd1000;

  // channel numbers in processing order
  localparam logic [2:0] CH_TEMP  = 3'd0;
  localparam logic [2:0] CH_LPG   = 3'd3;
  localparam logic [2:0] CH_SMOKE = 3'd4;
  localparam logic [2:0] CH_LAST  = 3'd4;

  // handshake between sequencer and shared divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/smaa_ram.sv =====
// ----------------------------------------------------------------------------
// smaa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/smaa_div.sv =====
// ----------------------------------------------------------------------------
// smaa_div
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module smaa_div
  import smaa_pkg::*;
#(
  parameter int DIVIDEND_W = 18,
  parameter int DIVISOR_W  = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // one restoring step
  always_comb begin
    shifted = {rem[DIVISOR_W-1:0], quo[DIVIDEND_W-1]};
    fits    = (shifted >= {1'b0, dsr});
    diff    = shifted - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff : shifted;
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== hdl/sensor_moving_average_alarm_top.sv =====
// ----------------------------------------------------------------------------
// sensor_moving_average_alarm_top
// Five-channel moving average over a ring window with a threshold alarm.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a ring window of WINDOW_LEN slots and
// one result follows: the truncated average of every channel over the samples
// held so far (one up to WINDOW_LEN), plus an alarm bit set when the exact
// average temperature, the average LPG or the average smoke exceeds its limit.
// The block works on one sample at a time and holds in_stall high meanwhile.
// The summing pass reads one window slot a cycle, and the single shared
// divider then produces one quotient bit a cycle for each of the five
// channels in turn; the channel sums are SUM_W = 15 + clog2(WINDOW_LEN + 1)
// bits wide. A finished result waits in the output register while the next
// sample is taken in; if the previous result is still held there, the block
// waits until it is taken. Limits are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while idle, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
module sensor_moving_average_alarm_top
  import smaa_pkg::*;
#(
  parameter int WINDOW_LEN = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // sample channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [TEMP_W-1:0]  temperature,
  input  logic [HUMID_W-1:0]        humidity,
  input  logic [PRESS_W-1:0]        pressure,
  input  logic [LPG_W-1:0]          lpg_ppm,
  input  logic [SMOKE_W-1:0]        smoke_ppm,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TEMP_W-1:0]  mean_temperature,
  output logic [HUMID_W-1:0]        mean_humidity,
  output logic [PRESS_W-1:0]        mean_pressure,
  output logic [LPG_W-1:0]          mean_lpg,
  output logic [SMOKE_W-1:0]        mean_smoke,
  output logic                      alarm
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = 15 + CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_LOAD
  } state_t;

  state_t state;

  // configuration registers
  logic signed [TEMP_W-1:0] temp_limit;
  logic [LPG_W-1:0]         lpg_limit;
  logic [SMOKE_W-1:0]       smoke_limit;

  // window bookkeeping
  logic [ADDR_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_level;
  logic [CNT_W-1:0]  rd_idx;
  logic              acc_en;

  // accumulation and division
  logic signed [SUM_W-1:0] sums [NCH];
  logic signed [SUM_W-1:0] temp_prod;
  logic                    temp_hot;
  logic [MEAN_W-1:0]       means [NCH];
  logic [2:0]              ch;
  logic                    div_wait;

  logic                in_take;
  logic                rd_more;
  logic [SAMPLE_W-1:0] wr_word;
  logic [SAMPLE_W-1:0] rd_word;

  logic signed [SUM_W-1:0] lim_ext;
  logic signed [SUM_W-1:0] cnt_ext;
  logic signed [SUM_W-1:0] cur_sum;
  logic                    cur_neg;
  logic [SUM_W-1:0]        cur_mag;
  logic [SUM_W-1:0]        quo;
  logic [SUM_W-1:0]        quo_signed;
  logic                    out_free;

  div_req_t  div_req;
  div_stat_t div_stat;

  // handshake
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rd_more  = (rd_idx < fill_level);

  // packed sample for the window
  assign wr_word = {smoke_ppm, lpg_ppm, pressure, humidity, temperature};

  // window storage
  smaa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (in_take),
    .waddr (write_slot),
    .wdata (wr_word),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_word)
  );

  // operands of the exact temperature test
  assign lim_ext = {{(SUM_W-TEMP_W){temp_limit[TEMP_W-1]}}, temp_limit};
  assign cnt_ext = {{(SUM_W-CNT_W){1'b0}}, fill_level};

  // divider operand: magnitude of the current channel sum
  always_comb begin
    cur_sum    = sums[ch];
    cur_neg    = cur_sum[SUM_W-1];
    cur_mag    = cur_neg ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    quo_signed = cur_neg ? (~quo + 1'b1) : quo;
  end

  assign div_req.start = (state == S_DIV) && !div_wait;

  // shared divider
  smaa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (cur_mag),
    .divisor  (fill_level),
    .stat     (div_stat),
    .quotient (quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit  <= TEMP_LIMIT_RST;
      lpg_limit   <= LPG_LIMIT_RST;
      smoke_limit <= SMOKE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_LIMIT:  temp_limit  <= cfg_data[TEMP_W-1:0];
        CFG_LPG_LIMIT:   lpg_limit   <= cfg_data[LPG_W-1:0];
        CFG_SMOKE_LIMIT: smoke_limit <= cfg_data[SMOKE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, window pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      write_slot <= '0;
      fill_level <= '0;
      rd_idx     <= '0;
      acc_en     <= 1'b0;
      ch         <= '0;
      div_wait   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a held result leaves once taken; S_LOAD refills the register itself
      if (out_valid && !out_stall && state != S_LOAD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (write_slot == ADDR_W'(WINDOW_LEN - 1)) begin
              write_slot <= '0;
            end else begin
              write_slot <= write_slot + 1'b1;
            end
            if (fill_level != CNT_W'(WINDOW_LEN)) begin
              fill_level <= fill_level + 1'b1;
            end
            rd_idx <= '0;
            acc_en <= 1'b0;
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          acc_en <= rd_more;
          if (rd_more) begin
            rd_idx <= rd_idx + 1'b1;
          end else if (!acc_en) begin
            ch       <= CH_TEMP;
            div_wait <= 1'b0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_req.start) begin
            div_wait <= 1'b1;
          end else if (div_stat.done) begin
            div_wait <= 1'b0;
            if (ch == CH_LAST) begin
              state <= S_LOAD;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // channel sums over the filled slots
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      for (int c = 0; c < NCH; c++) begin
        sums[c] <= '0;
      end
    end else if (state == S_SUM && acc_en) begin
      sums[0] <= sums[0] + {{(SUM_W-TEMP_W){rd_word[HUMID_LSB-1]}},
                            rd_word[HUMID_LSB-1:TEMP_LSB]};
      sums[1] <= sums[1] + {{(SUM_W-HUMID_W){1'b0}}, rd_word[PRESS_LSB-1:HUMID_LSB]};
      sums[2] <= sums[2] + {{(SUM_W-PRESS_W){1'b0}}, rd_word[LPG_LSB-1:PRESS_LSB]};
      sums[3] <= sums[3] + {{(SUM_W-LPG_W){1'b0}}, rd_word[SMOKE_LSB-1:LPG_LSB]};
      sums[4] <= sums[4] + {{(SUM_W-SMOKE_W){1'b0}}, rd_word[SAMPLE_W-1:SMOKE_LSB]};
    end
  end

  // exact temperature test: sum against limit times count
  always_ff @(posedge clk) begin
    temp_prod <= lim_ext * cnt_ext;
    if (state == S_SUM && !rd_more && !acc_en) begin
      temp_hot <= (sums[0] > temp_prod);
    end
  end

  // quotients, sign restored, kept per channel
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_stat.done) begin
      means[ch] <= quo_signed[MEAN_W-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      mean_temperature <= means[0][TEMP_W-1:0];
      mean_humidity    <= means[1][HUMID_W-1:0];
      mean_pressure    <= means[2][PRESS_W-1:0];
      mean_lpg         <= means[CH_LPG][LPG_W-1:0];
      mean_smoke       <= means[CH_SMOKE][SMOKE_W-1:0];
      alarm            <= temp_hot
                          || (means[CH_LPG][LPG_W-1:0] > lpg_limit)
                          || (means[CH_SMOKE][SMOKE_W-1:0] > smoke_limit);
    end
  end

endmodule

// ===== sim/tb_sensor_moving_average_alarm_top.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_moving_average_alarm_top
// Self-checking bench for the five-channel moving average alarm block.
// ----------------------------------------------------------------------------
// Samples go in through the valid/stall input channel. A scoreboard keeps its
// own ring window and limit registers, predicts the truncated channel means
// and the alarm bit for every accepted sample, and checks each result
// transaction field by field in order. The run starts with directed samples
// (field extremes, window fill and wrap, limit boundaries), then moves through
// phases of random samples. Between phases the block is drained and the limit
// registers are rewritten, extremes included. Sender bursts and gaps,
// receiver stalls and long receiver hold-offs vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_sensor_moving_average_alarm_top;
  timeunit 1ns;
  timeprecision 1ps;
  import smaa_pkg::*;

  localparam int WINDOW_LEN       = 5;
  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 11;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int END_CYCLES       = 150;
  localparam int HOLD_CYCLES      = 400;
  localparam int PHASES           = 12;
  localparam int SAMPLES_PER_PHASE = 128;
  localparam int MAX_PRINTED      = 50;

  // index with no register behind it, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUMID_W-1:0]       humidity;
    logic [PRESS_W-1:0]       pressure;
    logic [LPG_W-1:0]         lpg_ppm;
    logic [SMOKE_W-1:0]       smoke_ppm;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] mean_temperature;
    logic [HUMID_W-1:0]       mean_humidity;
    logic [PRESS_W-1:0]       mean_pressure;
    logic [LPG_W-1:0]         mean_lpg;
    logic [SMOKE_W-1:0]       mean_smoke;
    logic                     alarm;
  } mean_set_t;

  // window predictor and in-order result checker
  class mean_alarm_scoreboard;
    int        temp_hist[WINDOW_LEN];
    int        humid_hist[WINDOW_LEN];
    int        press_hist[WINDOW_LEN];
    int        lpg_hist[WINDOW_LEN];
    int        smoke_hist[WINDOW_LEN];
    int        write_slot;
    int        fill_level;
    int        temp_limit;
    int        lpg_limit;
    int        smoke_limit;
    mean_set_t expected_q[$];
    int        mismatches;

    function new();
      write_slot  = 0;
      fill_level  = 0;
      temp_limit  = int'(TEMP_LIMIT_RST);
      lpg_limit   = int'(LPG_LIMIT_RST);
      smoke_limit = int'(SMOKE_LIMIT_RST);
      mismatches  = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TEMP_LIMIT:  temp_limit = int'($signed(data[TEMP_W-1:0]));
        CFG_LPG_LIMIT:   lpg_limit = int'(data[LPG_W-1:0]);
        CFG_SMOKE_LIMIT: smoke_limit = int'(data[SMOKE_W-1:0]);
        default: ;
      endcase
    endfunction

    // store the sample and predict the means over the filled slots
    function void note_sample(sample_t s);
      int        sum_t, sum_h, sum_p, sum_l, sum_s;
      int        mean_l, mean_s;
      mean_set_t m;
      temp_hist[write_slot]  = int'($signed(s.temperature));
      humid_hist[write_slot] = int'(s.humidity);
      press_hist[write_slot] = int'(s.pressure);
      lpg_hist[write_slot]   = int'(s.lpg_ppm);
      smoke_hist[write_slot] = int'(s.smoke_ppm);
      write_slot = (write_slot + 1) % WINDOW_LEN;
      if (fill_level < WINDOW_LEN) fill_level++;
      sum_t = 0; sum_h = 0; sum_p = 0; sum_l = 0; sum_s = 0;
      for (int i = 0; i < fill_level; i++) begin
        sum_t += temp_hist[i];
        sum_h += humid_hist[i];
        sum_p += press_hist[i];
        sum_l += lpg_hist[i];
        sum_s += smoke_hist[i];
      end
      // int division truncates toward zero
      mean_l = sum_l / fill_level;
      mean_s = sum_s / fill_level;
      m.mean_temperature = TEMP_W'(sum_t / fill_level);
      m.mean_humidity    = HUMID_W'(sum_h / fill_level);
      m.mean_pressure    = PRESS_W'(sum_p / fill_level);
      m.mean_lpg         = LPG_W'(mean_l);
      m.mean_smoke       = SMOKE_W'(mean_s);
      // temperature test uses the exact average, gases the truncated one
      m.alarm = (sum_t > temp_limit * fill_level) || (mean_l > lpg_limit) ||
                (mean_s > smoke_limit);
      expected_q.push_back(m);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(mean_set_t got);
      mean_set_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with no sample pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("mean_temperature", 32'(got.mean_temperature),
                    32'(want.mean_temperature));
      compare_field("mean_humidity", 32'(got.mean_humidity), 32'(want.mean_humidity));
      compare_field("mean_pressure", 32'(got.mean_pressure), 32'(want.mean_pressure));
      compare_field("mean_lpg", 32'(got.mean_lpg), 32'(want.mean_lpg));
      compare_field("mean_smoke", 32'(got.mean_smoke), 32'(want.mean_smoke));
      compare_field("alarm", 32'(got.alarm), 32'(want.alarm));
    endtask
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] temperature;
  logic [HUMID_W-1:0]       humidity;
  logic [PRESS_W-1:0]       pressure;
  logic [LPG_W-1:0]         lpg_ppm;
  logic [SMOKE_W-1:0]       smoke_ppm;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [TEMP_W-1:0] mean_temperature;
  logic [HUMID_W-1:0]       mean_humidity;
  logic [PRESS_W-1:0]       mean_pressure;
  logic [LPG_W-1:0]         mean_lpg;
  logic [SMOKE_W-1:0]       mean_smoke;
  logic                     alarm;

  mean_alarm_scoreboard sb = new();
  int stall_pct     = 0;
  int hold_requests = 0;
  int cycle_count   = 0;

  sensor_moving_average_alarm_top #(
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .humidity         (humidity),
    .pressure         (pressure),
    .lpg_ppm          (lpg_ppm),
    .smoke_ppm        (smoke_ppm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_temperature (mean_temperature),
    .mean_humidity    (mean_humidity),
    .mean_pressure    (mean_pressure),
    .mean_lpg         (mean_lpg),
    .mean_smoke       (mean_smoke),
    .alarm            (alarm)
  );

  // clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check accepted transactions, stall on a pattern of its own
  initial begin
    int        stall_run;
    int        hold_left;
    int        holds_served;
    mean_set_t got;
    stall_run    = 0;
    hold_left    = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.mean_temperature = mean_temperature;
        got.mean_humidity    = mean_humidity;
        got.mean_pressure    = mean_pressure;
        got.mean_lpg         = mean_lpg;
        got.mean_smoke       = mean_smoke;
        got.alarm            = alarm;
        sb.check_result(got);
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_run = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sample_t mk_sample(int t, int h, int p, int l, int s);
    sample_t x;
    x.temperature = TEMP_W'(t);
    x.humidity    = HUMID_W'(h);
    x.pressure    = PRESS_W'(p);
    x.lpg_ppm     = LPG_W'(l);
    x.smoke_ppm   = SMOKE_W'(s);
    return x;
  endfunction

  // raw bit patterns, in-range values, or values around the current limits
  function automatic sample_t random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2)
      return mk_sample($urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind < 6)
      return mk_sample(int'($urandom_range(0, 1250)) - 400, $urandom_range(0, 1000),
                       $urandom_range(3000, 11000), $urandom_range(0, 10000),
                       $urandom_range(0, 10000));
    return mk_sample(clamp(sb.temp_limit + int'($urandom_range(0, 60)) - 30, -1024, 1023),
                     $urandom_range(0, 1000), $urandom_range(3000, 11000),
                     clamp(sb.lpg_limit + int'($urandom_range(0, 400)) - 200, 0, 16383),
                     clamp(sb.smoke_limit + int'($urandom_range(0, 400)) - 200, 0, 16383));
  endfunction

  // offer one sample and wait until the block takes it
  task send_sample(sample_t s);
    in_valid    <= 1'b1;
    temperature <= s.temperature;
    humidity    <= s.humidity;
    pressure    <= s.pressure;
    lpg_ppm     <= s.lpg_ppm;
    smoke_ppm   <= s.smoke_ppm;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  // random samples in bursts with idle gaps of up to gap_max
  task send_bursts(int count, int gap_max);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_sample(random_sample());
        left--;
      end
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  task wait_results_done();
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_limit(idx, data);
  endtask

  // all three limits plus a dropped write; spare temperature bits are random
  task apply_limits(logic [TEMP_W-1:0] t, logic [LPG_W-1:0] l, logic [SMOKE_W-1:0] s);
    logic [CFG_DATA_W-TEMP_W-1:0] spare;
    spare = (CFG_DATA_W-TEMP_W)'($urandom);
    write_limit(CFG_TEMP_LIMIT, {spare, t});
    write_limit(CFG_LPG_LIMIT, l);
    write_limit(CFG_INDEX_UNUSED, CFG_DATA_W'($urandom));
    write_limit(CFG_SMOKE_LIMIT, s);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // main sequence
  initial begin
    int gap_max;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_TEMP_LIMIT;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    temperature <= '0;
    humidity    <= '0;
    pressure    <= '0;
    lpg_ppm     <= '0;
    smoke_ppm   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed samples under the reset limits
    stall_pct = 30;
    send_sample(mk_sample(850, 1000, 11000, 10000, 10000));
    send_sample(mk_sample(-400, 0, 3000, 0, 0));
    send_sample(mk_sample(-1024, 1023, 16383, 16383, 16383));
    send_sample(mk_sample(1023, 0, 0, 0, 0));
    send_sample(mk_sample(-1, 1, 1, 1, 1));
    // window full of minimum codes, then of maximum codes
    repeat (WINDOW_LEN) send_sample(mk_sample(-1024, 0, 0, 0, 0));
    repeat (WINDOW_LEN) send_sample(mk_sample(1023, 1023, 16383, 16383, 16383));
    // averages sitting exactly on the limits, then one step above
    repeat (WINDOW_LEN) send_sample(mk_sample(220, 500, 10130, 800, 1000));
    send_sample(mk_sample(221, 500, 10130, 805, 1005));
    in_valid <= 1'b0;

    // random phases with new limits and idling each time
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: apply_limits(TEMP_W'(-1024), LPG_W'(0), SMOKE_W'(0));
        1: apply_limits(TEMP_W'(1023), LPG_W'(16383), SMOKE_W'(16383));
        2: apply_limits(TEMP_LIMIT_RST, LPG_LIMIT_RST, SMOKE_LIMIT_RST);
        3: apply_limits(TEMP_W'(-400), LPG_W'(10000), SMOKE_W'(10000));
        4: apply_limits(TEMP_W'(850), LPG_W'(0), SMOKE_W'(16383));
        default: begin
          if ($urandom_range(0, 3) == 0)
            apply_limits(TEMP_W'($urandom), LPG_W'($urandom), SMOKE_W'($urandom));
          else
            apply_limits(TEMP_W'(int'($urandom_range(0, 1250)) - 400),
                         LPG_W'($urandom_range(0, 10000)),
                         SMOKE_W'($urandom_range(0, 10000)));
        end
      endcase
      case (phase % 4)
        0: begin gap_max = 0;  stall_pct = 0;  end
        1: begin gap_max = 20; stall_pct = 30; end
        2: begin gap_max = 4;  stall_pct = 60; end
        default: begin gap_max = 40; stall_pct = 10; end
      endcase
      // long receiver hold-off while samples keep coming
      if (phase == 6 || phase == 10) begin
        hold_requests++;
        gap_max = 0;
      end
      send_bursts(SAMPLES_PER_PHASE, gap_max);
    end

    // drain and let any stray result show up
    stall_pct = 0;
    wait_results_done();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/smaa_pkg.sv
hdl/smaa_ram.sv
hdl/smaa_div.sv
hdl/sensor_moving_average_alarm_top.sv
sim/tb_sensor_moving_average_alarm_top.sv
